>>> hdl/acr_pkg.sv
// ----------------------------------------------------------------------------
// acr_pkg
// Shared types, constants and helper functions of the ASCII radix converter.
// ----------------------------------------------------------------------------
package acr_pkg;

   localparam int VALUE_BITS = 32;
   localparam int PROD_BITS  = VALUE_BITS + 7;
   localparam int CNT_BITS   = $clog2(VALUE_BITS);
   localparam int MAX_DIGITS = 32;
   localparam int DIG_ADDR_W = $clog2(MAX_DIGITS);
   localparam int DCNT_BITS  = DIG_ADDR_W + 1;
   localparam int BASE_BITS  = 6;

   // status codes
   localparam logic [1:0] STAT_OK       = 2'd0;
   localparam logic [1:0] STAT_BADCHAR  = 2'd1;
   localparam logic [1:0] STAT_BADDIGIT = 2'd2;
   localparam logic [1:0] STAT_OVERFLOW = 2'd3;

   // register indexes
   localparam logic REG_SOURCE_BASE = 1'b0;
   localparam logic REG_TARGET_BASE = 1'b1;

   localparam logic [BASE_BITS-1:0] SRC_BASE_RESET = 6'd10;
   localparam logic [BASE_BITS-1:0] TGT_BASE_RESET = 6'd2;
   localparam logic [BASE_BITS-1:0] BASE_MIN       = 6'd2;
   localparam logic [BASE_BITS-1:0] BASE_MAX       = 6'd36;

   localparam logic [7:0] CH_0     = 8'h30;
   localparam logic [7:0] CH_9     = 8'h39;
   localparam logic [7:0] CH_UPPER_A = 8'h41;
   localparam logic [7:0] CH_UPPER_Z = 8'h5A;
   localparam logic [7:0] CH_LOWER_A = 8'h61;
   localparam logic [7:0] CH_LOWER_Z = 8'h7A;
   localparam logic [7:0] CH_TEN   = 8'd10;

   typedef struct packed {
      logic [7:0] char_code;
      logic       end_of_number;
   } req_type;

   typedef struct packed {
      logic [7:0] out_char;
      logic [1:0] status;
      logic       last_of_run;
   } rsp_type;

   function automatic logic [BASE_BITS-1:0] clamp_base(input logic [BASE_BITS-1:0] b);
      logic [BASE_BITS-1:0] r;
      r = b;
      if (b < BASE_MIN) begin
         r = BASE_MIN;
      end else if (b > BASE_MAX) begin
         r = BASE_MAX;
      end
      return r;
   endfunction

   // bit 6 flags a legal character, bits 5:0 hold its digit value
   function automatic logic [BASE_BITS:0] char_to_digit(input logic [7:0] c);
      logic [7:0] d;
      logic       ok;
      d  = 8'd0;
      ok = 1'b1;
      if (c >= CH_0 && c <= CH_9) begin
         d = c - CH_0;
      end else if (c >= CH_UPPER_A && c <= CH_UPPER_Z) begin
         d = c - CH_UPPER_A + CH_TEN;
      end else if (c >= CH_LOWER_A && c <= CH_LOWER_Z) begin
         d = c - CH_LOWER_A + CH_TEN;
      end else begin
         ok = 1'b0;
      end
      return {ok, d[BASE_BITS-1:0]};
   endfunction

   function automatic logic [7:0] digit_to_char(input logic [BASE_BITS-1:0] d);
      logic [7:0] w;
      w = {2'b00, d};
      if (w < CH_TEN) begin
         return w + CH_0;
      end
      return w - CH_TEN + CH_UPPER_A;
   endfunction

endpackage

>>> hdl/acr_ram.sv
// ----------------------------------------------------------------------------
// acr_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module acr_ram #(
   parameter int WIDTH = 6,
   parameter int DEPTH = 32
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      rdata_ff <= mem_ff[raddr];
   end

   assign rdata = rdata_ff;

endmodule

>>> hdl/ascii_radix_converter_top.sv
// ----------------------------------------------------------------------------
// ascii_radix_converter_top
// Converts an ASCII numeral, one character per request, between radices.
// ----------------------------------------------------------------------------
// Usage: raise start with req_data while busy is low; the character is taken
// at that edge. Characters arrive most significant first and the one with
// end_of_number set closes the numeral. Each result appears on rsp_data for
// one cycle with rsp_strobe high; the receiver cannot stall, so results are
// simply presented. An errored numeral gives one result with its status.
// Operation: a legal character runs a shift-add multiply by the source base,
// one base bit per cycle, with busy high until it is done; a bad character
// does not raise busy. The end request then runs one restoring division per
// target digit, one quotient bit per cycle, storing the remainders in a
// small RAM, and then reads them back most significant first, one result
// after each RAM read.
// csr writes set the bases and are taken at once. Synchronous reset returns
// the bases to 10 and 2 and clears the accumulator and error state.
// ----------------------------------------------------------------------------
module ascii_radix_converter_top (
   input  logic                clock,
   input  logic                reset,
   input  logic                start,
   output logic                busy,
   input  acr_pkg::req_type    req_data,
   output logic                rsp_strobe,
   output acr_pkg::rsp_type    rsp_data,
   input  logic                csr_we,
   input  logic                csr_index,
   input  logic [5:0]          csr_wdata
);

   localparam logic [2:0] S_IDLE = 3'd0;
   localparam logic [2:0] S_MUL  = 3'd1;
   localparam logic [2:0] S_DIV  = 3'd2;
   localparam logic [2:0] S_RD   = 3'd3;
   localparam logic [2:0] S_OUT  = 3'd4;

   localparam int VB = acr_pkg::VALUE_BITS;
   localparam int PB = acr_pkg::PROD_BITS;
   localparam int BB = acr_pkg::BASE_BITS;
   localparam int CB = acr_pkg::CNT_BITS;
   localparam int DB = acr_pkg::DCNT_BITS;
   localparam int AB = acr_pkg::DIG_ADDR_W;

   logic [2:0]      state_ff,    state_in;
   logic [BB-1:0]   src_base_ff, tgt_base_ff;
   logic [VB-1:0]   value_ff,    value_in;
   logic [1:0]      err_ff,      err_in;
   logic [PB-1:0]   prod_ff,     prod_in;
   logic [PB-2:0]   mcand_ff,    mcand_in;
   logic [BB-1:0]   mplier_ff,   mplier_in;
   logic            end_ff,      end_in;
   logic [VB-1:0]   quot_ff,     quot_in;
   logic [BB-1:0]   rem_ff,      rem_in;
   logic [CB-1:0]   bit_cnt_ff,  bit_cnt_in;
   logic [DB-1:0]   dcount_ff,   dcount_in;
   logic            strobe_ff,   strobe_in;
   acr_pkg::rsp_type rsp_ff,     rsp_in;

   logic [BB-1:0]   src_base;
   logic [BB-1:0]   tgt_base;
   logic [BB:0]     dec;
   logic [BB:0]     rem_shift;
   logic            rem_ge;
   logic [BB-1:0]   rem_next;
   logic [VB-1:0]   quot_next;
   logic [DB-1:0]   dcount_inc;
   logic            fin;
   logic [1:0]      fin_err;
   logic [VB-1:0]   fin_val;
   logic            ram_we;
   logic [AB-1:0]   ram_raddr;
   logic [BB-1:0]   ram_rdata;

   assign src_base = acr_pkg::clamp_base(src_base_ff);
   assign tgt_base = acr_pkg::clamp_base(tgt_base_ff);
   assign dec      = acr_pkg::char_to_digit(req_data.char_code);

   // one restoring division step
   assign rem_shift  = {rem_ff, quot_ff[VB-1]};
   assign rem_ge     = rem_shift >= {1'b0, tgt_base};
   assign rem_next   = rem_ge ? BB'(rem_shift - {1'b0, tgt_base}) : rem_shift[BB-1:0];
   assign quot_next  = {quot_ff[VB-2:0], rem_ge};
   assign dcount_inc = dcount_ff + DB'(1);
   assign ram_raddr  = AB'(dcount_ff - DB'(1));

   acr_ram #(
      .WIDTH(BB),
      .DEPTH(acr_pkg::MAX_DIGITS)
   ) u_digits (
      .clock(clock),
      .we(ram_we),
      .waddr(dcount_ff[AB-1:0]),
      .wdata(rem_next),
      .raddr(ram_raddr),
      .rdata(ram_rdata)
   );

   always_comb begin
      state_in   = state_ff;
      value_in   = value_ff;
      err_in     = err_ff;
      prod_in    = prod_ff;
      mcand_in   = mcand_ff;
      mplier_in  = mplier_ff;
      end_in     = end_ff;
      quot_in    = quot_ff;
      rem_in     = rem_ff;
      bit_cnt_in = bit_cnt_ff;
      dcount_in  = dcount_ff;
      strobe_in  = 1'b0;
      rsp_in     = rsp_ff;
      ram_we     = 1'b0;
      fin        = 1'b0;
      fin_err    = err_ff;
      fin_val    = value_ff;

      case (state_ff)
         S_IDLE: begin
            if (start) begin
               if (err_ff == acr_pkg::STAT_OK) begin
                  if (!dec[BB]) begin
                     fin_err = acr_pkg::STAT_BADCHAR;
                     err_in  = acr_pkg::STAT_BADCHAR;
                     fin     = req_data.end_of_number;
                  end else if (dec[BB-1:0] >= src_base) begin
                     fin_err = acr_pkg::STAT_BADDIGIT;
                     err_in  = acr_pkg::STAT_BADDIGIT;
                     fin     = req_data.end_of_number;
                  end else begin
                     prod_in   = PB'(dec[BB-1:0]);
                     mcand_in  = (PB-1)'(value_ff);
                     mplier_in = src_base;
                     end_in    = req_data.end_of_number;
                     state_in  = S_MUL;
                  end
               end else begin
                  fin = req_data.end_of_number;
               end
            end
         end
         S_MUL: begin
            if (mplier_ff != '0) begin
               if (mplier_ff[0]) begin
                  prod_in = prod_ff + {1'b0, mcand_ff};
               end
               mcand_in  = {mcand_ff[PB-3:0], 1'b0};
               mplier_in = {1'b0, mplier_ff[BB-1:1]};
            end else begin
               fin_val = prod_ff[VB-1:0];
               if (prod_ff[PB-1:VB] != '0) begin
                  fin_err = acr_pkg::STAT_OVERFLOW;
                  err_in  = acr_pkg::STAT_OVERFLOW;
               end else begin
                  value_in = prod_ff[VB-1:0];
               end
               fin      = end_ff;
               state_in = S_IDLE;
            end
         end
         S_DIV: begin
            quot_in    = quot_next;
            rem_in     = rem_next;
            bit_cnt_in = bit_cnt_ff + CB'(1);
            if (bit_cnt_ff == CB'(VB - 1)) begin
               ram_we    = 1'b1;
               dcount_in = dcount_inc;
               rem_in    = '0;
               if (quot_next == '0) begin
                  state_in = S_RD;
               end else if (dcount_inc == DB'(acr_pkg::MAX_DIGITS)) begin
                  // more digits than the store holds
                  strobe_in          = 1'b1;
                  rsp_in.out_char    = 8'd0;
                  rsp_in.status      = acr_pkg::STAT_OVERFLOW;
                  rsp_in.last_of_run = 1'b1;
                  dcount_in          = '0;
                  state_in           = S_IDLE;
               end
            end
         end
         S_RD: begin
            state_in = S_OUT;
         end
         S_OUT: begin
            strobe_in          = 1'b1;
            rsp_in.out_char    = acr_pkg::digit_to_char(ram_rdata);
            rsp_in.status      = acr_pkg::STAT_OK;
            rsp_in.last_of_run = (dcount_ff == DB'(1));
            dcount_in          = dcount_ff - DB'(1);
            state_in           = (dcount_ff == DB'(1)) ? S_IDLE : S_RD;
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase

      // end of numeral: either report the error or start the divisions
      if (fin) begin
         value_in = '0;
         err_in   = acr_pkg::STAT_OK;
         if (fin_err != acr_pkg::STAT_OK) begin
            strobe_in          = 1'b1;
            rsp_in.out_char    = 8'd0;
            rsp_in.status      = fin_err;
            rsp_in.last_of_run = 1'b1;
            state_in           = S_IDLE;
         end else begin
            quot_in    = fin_val;
            rem_in     = '0;
            bit_cnt_in = '0;
            dcount_in  = '0;
            state_in   = S_DIV;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= S_IDLE;
         src_base_ff <= acr_pkg::SRC_BASE_RESET;
         tgt_base_ff <= acr_pkg::TGT_BASE_RESET;
         value_ff    <= '0;
         err_ff      <= acr_pkg::STAT_OK;
         dcount_ff   <= '0;
         strobe_ff   <= 1'b0;
      end else begin
         state_ff  <= state_in;
         value_ff  <= value_in;
         err_ff    <= err_in;
         dcount_ff <= dcount_in;
         strobe_ff <= strobe_in;
         if (csr_we) begin
            case (csr_index)
               acr_pkg::REG_SOURCE_BASE: src_base_ff <= csr_wdata;
               acr_pkg::REG_TARGET_BASE: tgt_base_ff <= csr_wdata;
               default: begin
               end
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      prod_ff    <= prod_in;
      mcand_ff   <= mcand_in;
      mplier_ff  <= mplier_in;
      end_ff     <= end_in;
      quot_ff    <= quot_in;
      rem_ff     <= rem_in;
      bit_cnt_ff <= bit_cnt_in;
      rsp_ff     <= rsp_in;
   end

   assign busy       = (state_ff != S_IDLE);
   assign rsp_strobe = strobe_ff;
   assign rsp_data   = rsp_ff;

endmodule
